@@ sv/i2a_pkg.sv @@
// shared types, constants and digit encoding for the integer to radix ascii converter
package i2a_pkg;

  localparam int unsigned BASE_W = 6;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;
  localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;
  localparam logic [BASE_W-1:0] DEC_BASE = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'h57;
  localparam logic [CHAR_W-1:0] CHAR_ERROR = 8'h00;

  // per item control word handed from the classifier to the converter
  typedef struct packed {
    logic              bad;
    logic              show_sign;
    logic [BASE_W-1:0] radix;
  } item_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CHAR_ZERO + dx;
    end else begin
      digit_char = CHAR_ALPHA_OFS + dx;
    end
  endfunction

endpackage

@@ sv/i2a_ram.sv @@
// generic single write port ram with registered read
module i2a_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/i2a_front.sv @@
// input side: takes items, checks the radix and forms the magnitude
module i2a_front
  import i2a_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            value_i,
  input  logic [BASE_W-1:0]      base_i,
  input  logic                   full_i,
  output logic                   push_o,
  output logic [VALUE_WIDTH-1:0] mag_o,
  output item_ctl_t              ctl_o
);

  localparam int unsigned VW = VALUE_WIDTH;

  logic [VW-1:0] raw;
  logic          neg;

  // narrow widths keep the low bits, wide widths see a non-negative value
  if (VW <= 32) begin : g_narrow
    assign raw = value_i[VW-1:0];
  end else begin : g_wide
    assign raw = {{(VW-32){1'b0}}, value_i};
  end

  assign neg = raw[VW-1];

  always_comb begin
    mag_o = neg ? (~raw + {{(VW-1){1'b0}}, 1'b1}) : raw;
    ctl_o.bad = (base_i < MIN_BASE) || (base_i > MAX_BASE);
    ctl_o.show_sign = neg && (base_i == DEC_BASE);
    ctl_o.radix = base_i;
  end

  assign in_ready_o = !full_i;
  assign push_o = in_valid_i && !full_i;

endmodule

@@ sv/i2a_queue.sv @@
// short queue of classified items between the input side and the converter
module i2a_queue
  import i2a_pkg::*;
#(
  parameter int unsigned WIDTH = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/i2a_back.sv @@
// converter: bit-serial radix divider, digit stack and output register
module i2a_back
  import i2a_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  logic [VALUE_WIDTH-1:0] head_mag_i,
  input  item_ctl_t              head_ctl_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   out_last_o,
  output logic                   out_bad_o
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(VW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [VW-1:0]     dvd_q, dvd_d;
  logic [BASE_W-1:0] rem_q, rem_d;
  logic [BASE_W-1:0] radix_q, radix_d;
  logic              sign_q, sign_d;
  logic [AW-1:0]     bit_q, bit_d;
  logic [AW-1:0]     idx_q, idx_d;

  logic              ov_q, ov_d;
  logic [CHAR_W-1:0] och_q, och_d;
  logic              olast_q, olast_d;
  logic              obad_q, obad_d;

  logic [BASE_W:0]   sh, diff;
  logic              ge;
  logic [BASE_W-1:0] rem_nxt;
  logic [VW-1:0]     quo_nxt;
  logic              out_free;
  logic              ram_we, ram_re;
  logic [BASE_W-1:0] ram_rdata;

  // one restoring step: next dividend bit into the partial remainder
  assign sh = {rem_q, dvd_q[VW-1]};
  assign diff = sh - {1'b0, radix_q};
  assign ge = (sh >= {1'b0, radix_q});
  assign rem_nxt = ge ? diff[BASE_W-1:0] : sh[BASE_W-1:0];
  assign quo_nxt = {dvd_q[VW-2:0], ge};

  assign out_free = !ov_q || out_ready_i;
  assign ram_we = (state_q == S_DIV) && (bit_q == AW'(VW - 1));
  assign ram_re = (state_q == S_RD);

  i2a_ram #(
    .WIDTH(BASE_W),
    .DEPTH(VW)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(rem_nxt),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    radix_d = radix_q;
    sign_d = sign_q;
    bit_d = bit_q;
    idx_d = idx_q;
    pop_o = 1'b0;
    och_d = och_q;
    olast_d = olast_q;
    obad_d = obad_q;
    ov_d = ov_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (head_ctl_i.bad) begin
            if (out_free) begin
              pop_o = 1'b1;
              ov_d = 1'b1;
              och_d = CHAR_ERROR;
              olast_d = 1'b1;
              obad_d = 1'b1;
            end
          end else begin
            pop_o = 1'b1;
            dvd_d = head_mag_i;
            rem_d = '0;
            radix_d = head_ctl_i.radix;
            sign_d = head_ctl_i.show_sign;
            bit_d = '0;
            idx_d = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d = rem_nxt;
        dvd_d = quo_nxt;
        bit_d = bit_q + 1'b1;
        if (bit_q == AW'(VW - 1)) begin
          bit_d = '0;
          rem_d = '0;
          if (quo_nxt == '0) begin
            state_d = sign_q ? S_SIGN : S_RD;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          ov_d = 1'b1;
          och_d = CHAR_MINUS;
          olast_d = 1'b0;
          obad_d = 1'b0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          och_d = digit_char(ram_rdata);
          olast_d = (idx_q == '0);
          obad_d = 1'b0;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    radix_q <= radix_d;
    sign_q <= sign_d;
    bit_q <= bit_d;
    idx_q <= idx_d;
    och_q <= och_d;
    olast_q <= olast_d;
    obad_q <= obad_d;
  end

  assign out_valid_o = ov_q;
  assign out_char_o = och_q;
  assign out_last_o = olast_q;
  assign out_bad_o = obad_q;

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && obad_q |-> olast_q && (och_q == CHAR_ERROR))
    else $error("bad radix result not a lone last transaction");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < radix_q)
    else $error("partial remainder reached the radix");

  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |=> state_q == S_OUT)
    else $error("digit read not followed by output step");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE) && !empty_i)
    else $error("queue popped outside idle");

endmodule

@@ sv/integer_to_radix_ascii.sv @@
// top level of the integer to radix ascii converter
// Converts a signed two's complement integer to ASCII digits in a radix of 2 to 36,
// most significant digit first, '0'-'9' then 'a'-'z'. A '-' leads only for a negative
// value in radix 10; other radices emit the digits of the magnitude alone. The last
// character of a conversion carries tlast. A radix outside 2..36 gives one transaction
// with character 0 and tuser set. The input side classifies each item and parks it in
// a two entry queue, so new items are taken while a conversion runs. The converter has
// one bit-serial restoring divider, which forms the digits least significant first and
// pushes each onto a digit stack; a '-', if shown, goes out next, then each digit is
// popped with a digit stack read followed by an output load. A bad radix item is popped
// and answered from the idle state once the output register is free. The output
// register lets the next character wait for the consumer without holding up the
// divider of the following item.
module integer_to_radix_ascii
  import i2a_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // value [31:0], base [37:32], zero fill
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // character [7:0]
  output logic        m_axis_tlast_o,
  output logic [0:0]  m_axis_tuser_o   // bad_base [0]
);

  localparam int unsigned QW = VALUE_WIDTH + $bits(item_ctl_t);

  logic                   q_full, q_empty, q_push, q_pop;
  logic [VALUE_WIDTH-1:0] front_mag, head_mag;
  item_ctl_t              front_ctl, head_ctl;
  logic [QW-1:0]          q_rdata;
  logic                   out_bad;

  // classify the incoming transaction
  i2a_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .value_i   (s_axis_tdata_i[31:0]),
    .base_i    (s_axis_tdata_i[37:32]),
    .full_i    (q_full),
    .push_o    (q_push),
    .mag_o     (front_mag),
    .ctl_o     (front_ctl)
  );

  // decouples the input handshake from the long running conversion
  i2a_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({front_mag, front_ctl}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  assign head_mag = q_rdata[QW-1 -: VALUE_WIDTH];
  assign head_ctl = q_rdata[$bits(item_ctl_t)-1:0];

  // divider, digit stack and output register
  i2a_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .head_mag_i (head_mag),
    .head_ctl_i (head_ctl),
    .pop_o      (q_pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_char_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_bad_o  (out_bad)
  );

  assign m_axis_tuser_o = out_bad;

endmodule
